/* rtl/ncdf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ncdf_pkg;

    localparam int IN_FRAC_BITS  = 12;
    localparam int OUT_FRAC_BITS = 16;
    localparam int SCORE_W       = 16;
    localparam int PROB_W        = OUT_FRAC_BITS + 1;
    localparam int MAG_W         = SCORE_W - 1;

    localparam int WORK_FRAC    = 30;
    localparam int WORD_W       = 32;
    localparam int PROD_W       = 2 * WORD_W;
    localparam int HORNER_STEPS = 5;
    localparam int SQUARINGS    = 3;
    localparam int DIV_W        = 64;
    localparam int QUO_W        = OUT_FRAC_BITS;

    localparam longint unsigned DEC_SCALE = 64'd10000000000;
    localparam longint unsigned Q30_UNIT  = 64'd1 << WORK_FRAC;

    localparam logic [63:0] C1_FULL  = (64'd705230784 * Q30_UNIT + DEC_SCALE / 2) / DEC_SCALE;
    localparam logic [63:0] C2_FULL  = (64'd422820123 * Q30_UNIT + DEC_SCALE / 2) / DEC_SCALE;
    localparam logic [63:0] C3_FULL  = (64'd92705272 * Q30_UNIT + DEC_SCALE / 2) / DEC_SCALE;
    localparam logic [63:0] C4_FULL  = (64'd1520143 * Q30_UNIT + DEC_SCALE / 2) / DEC_SCALE;
    localparam logic [63:0] C5_FULL  = (64'd2765672 * Q30_UNIT + DEC_SCALE / 2) / DEC_SCALE;
    localparam logic [63:0] C6_FULL  = (64'd430638 * Q30_UNIT + DEC_SCALE / 2) / DEC_SCALE;
    localparam logic [63:0] INV_FULL = (64'd7071067812 * Q30_UNIT + DEC_SCALE / 2) / DEC_SCALE;

    localparam logic [WORD_W-1:0] INV_SQRT2_Q30 = INV_FULL[WORD_W-1:0];
    localparam logic [WORD_W-1:0] COEF_C6_Q30   = C6_FULL[WORD_W-1:0];
    localparam logic [WORD_W-1:0] WORK_ONE      = Q30_UNIT[WORD_W-1:0];

    // Addends of the Horner steps in evaluation order; the last one is the leading 1.
    localparam logic [WORD_W-1:0] HORNER_ADD [HORNER_STEPS + 1] = '{
        C5_FULL[WORD_W-1:0],
        C4_FULL[WORD_W-1:0],
        C3_FULL[WORD_W-1:0],
        C2_FULL[WORD_W-1:0],
        C1_FULL[WORD_W-1:0],
        WORK_ONE
    };

    localparam int SQ_SHIFT [SQUARINGS] = '{32, 30, 32};

    localparam logic [PROD_W-1:0] Y_HALF    = PROD_W'(1) << (IN_FRAC_BITS - 1);
    localparam logic [PROD_W-1:0] WORK_HALF = PROD_W'(1) << (WORK_FRAC - 1);
    localparam logic [DIV_W-1:0]  NUM_ONE   = DIV_W'(1) << (39 + OUT_FRAC_BITS);
    localparam logic [PROB_W-1:0] PROB_ONE  = PROB_W'(1) << OUT_FRAC_BITS;

    localparam logic signed [SCORE_W-1:0] TAIL_POS = SCORE_W'(5 << IN_FRAC_BITS);
    localparam logic signed [SCORE_W-1:0] TAIL_NEG = -TAIL_POS;

    typedef struct packed {
        logic neg;
        logic low_tail;
        logic high_tail;
    } ncdf_side_t;

endpackage

`default_nettype wire

/* rtl/ncdf_poly.sv */
`timescale 1ns / 1ps
`default_nettype none

module ncdf_poly (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  ncdf_pkg::ncdf_side_t        in_side,
    input  logic [ncdf_pkg::MAG_W-1:0]  in_mag,
    output logic                        out_valid,
    input  logic                        out_ready,
    output ncdf_pkg::ncdf_side_t        out_side,
    output logic [ncdf_pkg::WORD_W-1:0] out_p
);
    import ncdf_pkg::*;

    localparam int PAIRS  = HORNER_STEPS + 2;
    localparam int STAGES = 2 * PAIRS;

    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] v_feed;
    logic [STAGES-1:0] adv;
    ncdf_side_t        side_reg [STAGES];
    logic [PROD_W-1:0] prod_reg [PAIRS];
    logic [WORD_W-1:0] ym_reg   [1:PAIRS-1];
    logic [WORD_W-1:0] y_reg    [PAIRS];
    logic [WORD_W-1:0] acc_reg  [PAIRS];

    // A stage may load when it is empty, some stage after it has room, or out_ready is high.
    always_comb
    begin
        for (int s = 0; s < STAGES; s++)
        begin
            adv[s] = out_ready || (((~v_reg) >> s) != '0);
        end
    end

    assign v_feed   = {v_reg[STAGES-2:0], in_valid};
    assign in_ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int s = 0; s < STAGES; s++)
            begin
                if (adv[s])
                begin
                    v_reg[s] <= v_feed[s];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            prod_reg[0] <= PROD_W'(in_mag) * PROD_W'(INV_SQRT2_Q30);
            side_reg[0] <= in_side;
        end
        if (adv[1])
        begin
            y_reg[0]    <= WORD_W'((prod_reg[0] + Y_HALF) >> IN_FRAC_BITS);
            acc_reg[0]  <= COEF_C6_Q30;
            side_reg[1] <= side_reg[0];
        end
        for (int m = 1; m < PAIRS; m++)
        begin
            if (adv[2 * m])
            begin
                prod_reg[m]     <= PROD_W'(y_reg[m - 1]) * PROD_W'(acc_reg[m - 1]);
                ym_reg[m]       <= y_reg[m - 1];
                side_reg[2 * m] <= side_reg[2 * m - 1];
            end
            if (adv[2 * m + 1])
            begin
                acc_reg[m]          <= HORNER_ADD[m - 1]
                                       + WORD_W'((prod_reg[m] + WORK_HALF) >> WORK_FRAC);
                y_reg[m]            <= ym_reg[m];
                side_reg[2 * m + 1] <= side_reg[2 * m];
            end
        end
    end

    assign out_valid = v_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];
    assign out_p     = acc_reg[PAIRS-1];

endmodule

`default_nettype wire

/* rtl/ncdf_pow.sv */
`timescale 1ns / 1ps
`default_nettype none

module ncdf_pow (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  ncdf_pkg::ncdf_side_t        in_side,
    input  logic [ncdf_pkg::WORD_W-1:0] in_p,
    output logic                        out_valid,
    input  logic                        out_ready,
    output ncdf_pkg::ncdf_side_t        out_side,
    output logic [ncdf_pkg::DIV_W-1:0]  out_p16
);
    import ncdf_pkg::*;

    localparam int STAGES = 2 * SQUARINGS + 1;

    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] v_feed;
    logic [STAGES-1:0] adv;
    ncdf_side_t        side_reg [STAGES];
    logic [WORD_W-1:0] sq_feed  [SQUARINGS];
    logic [PROD_W-1:0] prod_reg [SQUARINGS];
    logic [WORD_W-1:0] sq_reg   [SQUARINGS];
    logic [DIV_W-1:0]  p16_reg;

    always_comb
    begin
        for (int s = 0; s < STAGES; s++)
        begin
            adv[s] = out_ready || (((~v_reg) >> s) != '0);
        end
    end

    always_comb
    begin
        sq_feed[0] = in_p;
        for (int i = 1; i < SQUARINGS; i++)
        begin
            sq_feed[i] = sq_reg[i - 1];
        end
    end

    assign v_feed   = {v_reg[STAGES-2:0], in_valid};
    assign in_ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int s = 0; s < STAGES; s++)
            begin
                if (adv[s])
                begin
                    v_reg[s] <= v_feed[s];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            side_reg[0] <= in_side;
        end
        for (int s = 1; s < STAGES; s++)
        begin
            if (adv[s])
            begin
                side_reg[s] <= side_reg[s - 1];
            end
        end
        for (int i = 0; i < SQUARINGS; i++)
        begin
            if (adv[2 * i])
            begin
                prod_reg[i] <= PROD_W'(sq_feed[i]) * PROD_W'(sq_feed[i]);
            end
            if (adv[2 * i + 1])
            begin
                sq_reg[i] <= WORD_W'((prod_reg[i] + (PROD_W'(1) << (SQ_SHIFT[i] - 1)))
                                     >> SQ_SHIFT[i]);
            end
        end
        if (adv[STAGES-1])
        begin
            p16_reg <= DIV_W'(sq_reg[SQUARINGS-1]) * DIV_W'(sq_reg[SQUARINGS-1]);
        end
    end

    assign out_valid = v_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];
    assign out_p16   = p16_reg;

endmodule

`default_nettype wire

/* rtl/ncdf_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module ncdf_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  ncdf_pkg::ncdf_side_t       in_side,
    input  logic [ncdf_pkg::DIV_W-1:0] in_p16,
    output logic                       out_valid,
    input  logic                       out_ready,
    output ncdf_pkg::ncdf_side_t       out_side,
    output logic [ncdf_pkg::QUO_W-1:0] out_t
);
    import ncdf_pkg::*;

    localparam int STAGES = QUO_W + 1;

    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] v_feed;
    logic [STAGES-1:0] adv;
    logic [DIV_W-1:0]  div_num;
    ncdf_side_t        side_reg [STAGES];
    logic [DIV_W-1:0]  rem_reg  [QUO_W];
    logic [DIV_W-1:0]  d_reg    [QUO_W];
    logic [QUO_W-1:0]  bits_reg [STAGES];
    logic [DIV_W:0]    trial    [1:QUO_W];
    logic [QUO_W:1]    ge;
    logic [DIV_W-1:0]  rem_next [1:QUO_W-1];

    always_comb
    begin
        for (int s = 0; s < STAGES; s++)
        begin
            adv[s] = out_ready || (((~v_reg) >> s) != '0);
        end
    end

    // The rounding half is folded into the dividend.
    assign div_num = NUM_ONE + (in_p16 >> 1);

    // One restoring step per stage: the next dividend bit comes off the top of
    // the bit register and the quotient bit enters at its bottom.
    always_comb
    begin
        for (int j = 1; j <= QUO_W; j++)
        begin
            trial[j] = {rem_reg[j - 1], bits_reg[j - 1][QUO_W-1]};
            ge[j]    = trial[j] >= {1'b0, d_reg[j - 1]};
        end
        for (int j = 1; j < QUO_W; j++)
        begin
            rem_next[j] = ge[j] ? DIV_W'(trial[j] - {1'b0, d_reg[j - 1]}) : DIV_W'(trial[j]);
        end
    end

    assign v_feed   = {v_reg[STAGES-2:0], in_valid};
    assign in_ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int s = 0; s < STAGES; s++)
            begin
                if (adv[s])
                begin
                    v_reg[s] <= v_feed[s];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            side_reg[0] <= in_side;
            rem_reg[0]  <= div_num >> QUO_W;
            bits_reg[0] <= div_num[QUO_W-1:0];
            d_reg[0]    <= in_p16;
        end
        for (int j = 1; j <= QUO_W; j++)
        begin
            if (adv[j])
            begin
                side_reg[j] <= side_reg[j - 1];
                bits_reg[j] <= {bits_reg[j - 1][QUO_W-2:0], ge[j]};
            end
        end
        for (int j = 1; j < QUO_W; j++)
        begin
            if (adv[j])
            begin
                rem_reg[j] <= rem_next[j];
                d_reg[j]   <= d_reg[j - 1];
            end
        end
    end

    assign out_valid = v_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];
    assign out_t     = bits_reg[STAGES-1];

endmodule

`default_nettype wire

/* rtl/normal_cdf_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Standard normal cumulative distribution. Each item carries a signed score in
// Q4.12 and returns its probability in unsigned Q1.16, where 65536 is 1.0; scores
// beyond plus or minus 5.0 give exactly 1 or 0. The unit takes one item per clock
// while the output is not stalled. 14 stages form the scaled magnitude and the
// sixth-order polynomial, 7 stages raise it to the 16th power by four squarings,
// 17 stages form the reciprocal with a one bit per stage restoring divider, and
// one stage holds the result. A stalled output holds each item in place; empty
// stages keep filling, so new items are taken until the pipeline is full.

module normal_cdf_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [ncdf_pkg::SCORE_W-1:0] standard_score,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic        [ncdf_pkg::PROB_W-1:0]  probability
);
    import ncdf_pkg::*;

    ncdf_side_t          in_side;
    logic [MAG_W-1:0]    score_abs;
    logic [MAG_W-1:0]    in_mag;

    logic                poly_valid;
    logic                poly_ready;
    ncdf_side_t          poly_side;
    logic [WORD_W-1:0]   poly_p;

    logic                pow_valid;
    logic                pow_ready;
    ncdf_side_t          pow_side;
    logic [DIV_W-1:0]    pow_p16;

    logic                div_valid;
    logic                div_ready;
    ncdf_side_t          div_side;
    logic [QUO_W-1:0]    div_t;

    logic                out_valid_reg;
    logic [PROB_W-1:0]   prob_reg;
    logic [PROB_W-1:0]   prob_next;

    always_comb
    begin
        in_side.neg       = standard_score[SCORE_W-1];
        in_side.low_tail  = standard_score < TAIL_NEG;
        in_side.high_tail = standard_score > TAIL_POS;
        score_abs = in_side.neg ? MAG_W'(-standard_score) : MAG_W'(standard_score);
        in_mag    = (in_side.low_tail || in_side.high_tail) ? '0 : score_abs;
    end

    ncdf_poly u_poly (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_side   (in_side),
        .in_mag    (in_mag),
        .out_valid (poly_valid),
        .out_ready (poly_ready),
        .out_side  (poly_side),
        .out_p     (poly_p)
    );

    ncdf_pow u_pow (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (poly_valid),
        .in_ready  (poly_ready),
        .in_side   (poly_side),
        .in_p      (poly_p),
        .out_valid (pow_valid),
        .out_ready (pow_ready),
        .out_side  (pow_side),
        .out_p16   (pow_p16)
    );

    ncdf_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pow_valid),
        .in_ready  (pow_ready),
        .in_side   (pow_side),
        .in_p16    (pow_p16),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_side  (div_side),
        .out_t     (div_t)
    );

    assign div_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        priority if (div_side.low_tail)
        begin
            prob_next = '0;
        end
        else if (div_side.high_tail)
        begin
            prob_next = PROB_ONE;
        end
        else if (div_side.neg)
        begin
            prob_next = PROB_W'(div_t);
        end
        else
        begin
            prob_next = PROB_ONE - PROB_W'(div_t);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (div_ready)
        begin
            out_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_ready && div_valid)
        begin
            prob_reg <= prob_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign probability = prob_reg;

endmodule

`default_nettype wire

/* verif/tb_normal_cdf_unit.sv */
`timescale 1ns / 1ps

class phi_ledger;

    typedef struct {
        logic signed [ncdf_pkg::SCORE_W-1:0] score;
        logic [ncdf_pkg::PROB_W-1:0]         prob;
    } phi_entry_t;

    phi_entry_t      awaited_phi[$];
    longint unsigned coef_q30[6];
    longint unsigned rsqrt2_q30;
    int              scores_taken;
    int              probs_checked;
    int              mismatches;
    int              orphans;
    int              low_tail_hits;
    int              high_tail_hits;
    int              poly_hits;

    function new();
        coef_q30[0] = dec10_to_q30(64'd705230784);
        coef_q30[1] = dec10_to_q30(64'd422820123);
        coef_q30[2] = dec10_to_q30(64'd92705272);
        coef_q30[3] = dec10_to_q30(64'd1520143);
        coef_q30[4] = dec10_to_q30(64'd2765672);
        coef_q30[5] = dec10_to_q30(64'd430638);
        rsqrt2_q30  = dec10_to_q30(64'd7071067812);
        scores_taken   = 0;
        probs_checked  = 0;
        mismatches     = 0;
        orphans        = 0;
        low_tail_hits  = 0;
        high_tail_hits = 0;
        poly_hits      = 0;
    endfunction

    // Ten decimal digits after the point, rounded to nearest in Q30.
    function longint unsigned dec10_to_q30(longint unsigned digits);
        return (digits * (64'd1 << 30) + 64'd5000000000) / 64'd10000000000;
    endfunction

    function longint unsigned mul_rnd(longint unsigned a, longint unsigned b, int sh);
        return (a * b + (64'd1 << (sh - 1))) >> sh;
    endfunction

    function logic [ncdf_pkg::PROB_W-1:0] phi_of(logic signed [ncdf_pkg::SCORE_W-1:0] score);
        int              s;
        int              edge5;
        longint unsigned mag;
        longint unsigned y;
        longint unsigned acc;
        longint unsigned p;
        longint unsigned p2;
        longint unsigned p4;
        longint unsigned p8;
        longint unsigned p16;
        longint unsigned t;
        longint unsigned one_out;
        s       = score;
        edge5   = 5 << ncdf_pkg::IN_FRAC_BITS;
        one_out = 64'd1 << ncdf_pkg::OUT_FRAC_BITS;
        if (s < -edge5)
            return '0;
        if (s > edge5)
            return ncdf_pkg::PROB_W'(one_out);
        mag = longint'(s < 0 ? -s : s);
        y   = mul_rnd(mag, rsqrt2_q30, ncdf_pkg::IN_FRAC_BITS);
        acc = coef_q30[5];
        for (int k = 4; k >= 0; k--)
            acc = coef_q30[k] + mul_rnd(y, acc, 30);
        p   = (64'd1 << 30) + mul_rnd(y, acc, 30);
        p2  = mul_rnd(p, p, 32);
        p4  = mul_rnd(p2, p2, 30);
        p8  = mul_rnd(p4, p4, 32);
        p16 = p8 * p8;
        if (p16 == 0)
            p16 = 1;
        t = ((64'd1 << (39 + ncdf_pkg::OUT_FRAC_BITS)) + (p16 >> 1)) / p16;
        if (t > one_out)
            t = one_out;
        return ncdf_pkg::PROB_W'(s < 0 ? t : one_out - t);
    endfunction

    function void note_score(logic signed [ncdf_pkg::SCORE_W-1:0] score);
        phi_entry_t e;
        int         s;
        s       = score;
        e.score = score;
        e.prob  = phi_of(score);
        awaited_phi.push_back(e);
        scores_taken++;
        if (s < -(5 << ncdf_pkg::IN_FRAC_BITS))
            low_tail_hits++;
        else if (s > (5 << ncdf_pkg::IN_FRAC_BITS))
            high_tail_hits++;
        else
            poly_hits++;
    endfunction

    function void check_probability(logic [ncdf_pkg::PROB_W-1:0] prob);
        phi_entry_t e;
        if (awaited_phi.size() == 0)
        begin
            orphans++;
            if (mismatches + orphans <= 10)
                $display("unexpected probability %0d with no score outstanding", prob);
            return;
        end
        e = awaited_phi.pop_front();
        probs_checked++;
        if (prob !== e.prob)
        begin
            mismatches++;
            if (mismatches + orphans <= 10)
                $display("mismatch: score %0d expected probability %0d, got %0d",
                         e.score, e.prob, prob);
        end
    endfunction

    function int outstanding();
        return awaited_phi.size();
    endfunction

    function bit failed();
        return (mismatches != 0) || (orphans != 0) || (awaited_phi.size() != 0);
    endfunction

endclass

module tb_normal_cdf_unit;

    localparam int RANDOM_ITEMS  = 1330;
    localparam int HOLD_CYCLES   = 160;
    localparam int PRESSURE_RUN  = 200;
    localparam int DRAIN_CYCLES  = 60;
    localparam int STALL_LIMIT   = 4000;

    logic                                clk;
    logic                                rst_n;
    logic                                in_valid;
    logic                                in_ready;
    logic signed [ncdf_pkg::SCORE_W-1:0] standard_score;
    logic                                out_valid;
    logic                                out_ready;
    logic        [ncdf_pkg::PROB_W-1:0]  probability;

    phi_ledger ledger;
    bit        hold_request;
    bit        hold_seen;
    int        quiet_cycles;

    normal_cdf_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .standard_score (standard_score),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .probability    (probability)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic send_score(input logic signed [ncdf_pkg::SCORE_W-1:0] value);
        @(negedge clk);
        in_valid       = 1'b1;
        standard_score = value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    function automatic logic signed [ncdf_pkg::SCORE_W-1:0] pick_score();
        int kind;
        int v;
        int edge5;
        edge5 = 5 << ncdf_pkg::IN_FRAC_BITS;
        kind  = $urandom_range(0, 99);
        if (kind < 68)
            v = int'($urandom_range(0, 2 * edge5)) - edge5;
        else if (kind < 76)
            v = int'($urandom_range(0, 512)) - 256;
        else if (kind < 86)
        begin
            v = edge5 + int'($urandom_range(0, 8)) - 4;
            if ($urandom_range(0, 1))
                v = -v;
        end
        else if (kind < 93)
        begin
            v = int'($urandom_range(edge5 + 1, 32767));
            if ($urandom_range(0, 1))
                v = -v - 1;
        end
        else
            v = int'($urandom_range(0, 65535));
        return v[ncdf_pkg::SCORE_W-1:0];
    endfunction

    // Result side: a long hold-off on request, otherwise segments of varied stall patterns.
    initial
    begin
        int mode;
        int span;
        int tick;
        out_ready = 1'b0;
        hold_seen = 1'b0;
        tick      = 0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request && !hold_seen)
            begin
                @(negedge clk);
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_seen = 1'b1;
                out_ready = 1'b1;
            end
            else
            begin
                mode = $urandom_range(0, 4);
                span = $urandom_range(10, 80);
                repeat (span)
                begin
                    @(negedge clk);
                    tick++;
                    case (mode)
                        0: out_ready = 1'b1;
                        1: out_ready = 1'($urandom_range(0, 1));
                        2: out_ready = (tick % 5) < 3;
                        3: out_ready = ($urandom_range(0, 7) == 0);
                        default: out_ready = ($urandom_range(0, 9) != 0);
                    endcase
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (out_valid && out_ready)
                ledger.check_probability(probability);
            if (in_valid && in_ready)
                ledger.note_score(standard_score);
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout after %0d cycles without a handshake", quiet_cycles);
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        logic signed [ncdf_pkg::SCORE_W-1:0] directed[$];
        int sent;
        int burst;
        bit pressure_done;
        ledger         = new();
        in_valid       = 1'b0;
        standard_score = '0;
        rst_n          = 1'b0;
        hold_request   = 1'b0;
        pressure_done  = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Extremes, exactly +/-5.0 and its neighbors, zero and a few ordinary scores.
        directed = '{16'sh8000, 16'sh7FFF, 16'sd0, 16'sd1, -16'sd1,
                     16'sd20480, -16'sd20480, 16'sd20481, -16'sd20481,
                     16'sd20479, -16'sd20479, 16'sd4096, -16'sd4096,
                     16'sd8192, -16'sd8192, 16'sd12288, -16'sd12288,
                     16'sd2896, -16'sd2896, 16'sh5555, 16'shAAAA,
                     16'sd16384, -16'sd16384};
        foreach (directed[i])
            send_score(directed[i]);
        pause_sender(5);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (!pressure_done && sent >= 400)
            begin
                hold_request = 1'b1;
                repeat (PRESSURE_RUN) send_score(pick_score());
                sent += PRESSURE_RUN;
                pressure_done = 1'b1;
            end
            burst = $urandom_range(1, 40);
            repeat (burst) send_score(pick_score());
            sent += burst;
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 12));
        end
        pause_sender(1);

        while (ledger.outstanding() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d scores taken, %0d probabilities checked, %0d mismatches",
                 ledger.scores_taken, ledger.probs_checked, ledger.mismatches + ledger.orphans);
        $display("summary: %0d below -5, %0d above +5, %0d on the polynomial path",
                 ledger.low_tail_hits, ledger.high_tail_hits, ledger.poly_hits);
        if (ledger.failed())
            $display("tb: failure");
        else
            $display("tb: success");
        $finish;
    end

endmodule

/* sim.f */
rtl/ncdf_pkg.sv
rtl/ncdf_poly.sv
rtl/ncdf_pow.sv
rtl/ncdf_div.sv
rtl/normal_cdf_unit.sv
verif/tb_normal_cdf_unit.sv
